// ===== rtl/bcc_pkg.sv =====
// Shared types, codes and reset values for the button click classifier.
`default_nettype none
package bcc_pkg;

	localparam int unsigned MsW  = 16;
	localparam int unsigned DtW  = 8;
	localparam int unsigned EvW  = 2;
	localparam int unsigned IdxW = 2;

	localparam logic [MsW-1:0] ClickMsReset  = 16'd300;
	localparam logic [MsW-1:0] HoldMsReset   = 16'd1000;
	localparam logic [MsW-1:0] IgnoreMsReset = 16'd500;

	// register indexes on the configuration channel
	localparam logic [IdxW-1:0] RegClickMs  = 2'd0;
	localparam logic [IdxW-1:0] RegHoldMs   = 2'd1;
	localparam logic [IdxW-1:0] RegIgnoreMs = 2'd2;

	typedef enum logic [EvW-1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} bcc_event_t;

	typedef enum logic [5:0] {
		PH_IDLE         = 6'b000001,
		PH_FIRSTPRESS   = 6'b000010,
		PH_FIRSTHOLD    = 6'b000100,
		PH_FIRSTRELEASE = 6'b001000,
		PH_SECONDPRESS  = 6'b010000,
		PH_IGNORE       = 6'b100000
	} bcc_phase_t;

	typedef struct packed {
		bcc_phase_t     phase;
		logic [MsW-1:0] timer;
		logic           pending;
		logic           level;
	} bcc_state_t;

	typedef struct packed {
		logic [MsW-1:0] click_ms;
		logic [MsW-1:0] hold_ms;
		logic [MsW-1:0] ignore_ms;
	} bcc_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/bcc_if.sv =====
// Handshake channel interfaces: item, result and configuration write.
`default_nettype none
interface bcc_item_if;
	logic                   valid;
	logic                   ready;
	logic                   action;
	logic [bcc_pkg::DtW-1:0] elapsed_ms;
	logic                   button_level;
	modport source (output valid, action, elapsed_ms, button_level, input ready);
	modport sink   (input valid, action, elapsed_ms, button_level, output ready);
endinterface

interface bcc_result_if;
	logic                   valid;
	logic                   ready;
	logic [bcc_pkg::EvW-1:0] click_event;
	logic                   busy_res;
	modport source (output valid, click_event, busy_res, input ready);
	modport sink   (input valid, click_event, busy_res, output ready);
endinterface

interface bcc_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [bcc_pkg::IdxW-1:0] index;
	logic [bcc_pkg::MsW-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bcc_core.sv =====
// Next-state and event logic for one item: timeouts, then the pending edge.
`default_nettype none
module bcc_core
	import bcc_pkg::*;
(
	input  bcc_state_t       cur,
	input  bcc_cfg_t         cfg,
	input  logic             action,
	input  logic [DtW-1:0]   elapsed_ms,
	input  logic             button_level,
	output bcc_state_t       nxt,
	output bcc_event_t       click_event
);

	logic [MsW:0]   sum;
	logic [MsW-1:0] timer_adv;
	bcc_phase_t     ph_to;
	bcc_event_t     ev_to;
	logic           take;

	// saturating advance of the phase timer
	assign sum       = {1'b0, cur.timer} + {{(MsW+1-DtW){1'b0}}, elapsed_ms};
	assign timer_adv = sum[MsW] ? {MsW{1'b1}} : sum[MsW-1:0];
	assign take      = cur.pending && (cur.phase != PH_IGNORE);

	// timeouts
	always_comb begin
		ph_to = cur.phase;
		ev_to = EV_NONE;
		unique case (cur.phase)
			PH_FIRSTPRESS: begin
				if (timer_adv > cfg.click_ms) ph_to = PH_FIRSTHOLD;
			end
			PH_FIRSTHOLD: begin
				if (timer_adv > cfg.hold_ms) begin
					ph_to = PH_IDLE;
					ev_to = EV_LONG;
				end
			end
			PH_FIRSTRELEASE: begin
				if (timer_adv > cfg.click_ms) begin
					ph_to = PH_IDLE;
					ev_to = EV_SINGLE;
				end
			end
			PH_SECONDPRESS: begin
				if (timer_adv > cfg.click_ms) ph_to = PH_IDLE;
			end
			PH_IGNORE: begin
				if (timer_adv > cfg.ignore_ms) ph_to = PH_IDLE;
			end
			default: ph_to = PH_IDLE;
		endcase
	end

	always_comb begin
		nxt         = cur;
		click_event = EV_NONE;
		if (action) begin
			nxt.level   = button_level;
			nxt.pending = 1'b1;
		end else begin
			nxt.pending = 1'b0;
			// idle holds the timer
			if (cur.phase != PH_IDLE) nxt.timer = timer_adv;
			nxt.phase   = ph_to;
			click_event = ev_to;
			if (take) begin
				nxt.timer = '0;
				unique case (ph_to)
					PH_IDLE:         nxt.phase = cur.level ? PH_FIRSTPRESS : PH_IDLE;
					PH_FIRSTPRESS:   nxt.phase = cur.level ? PH_IDLE : PH_FIRSTRELEASE;
					PH_FIRSTRELEASE: nxt.phase = cur.level ? PH_SECONDPRESS : PH_IDLE;
					PH_SECONDPRESS: begin
						if (!cur.level) begin
							nxt.phase   = PH_IGNORE;
							click_event = EV_DOUBLE;
						end else begin
							nxt.phase = PH_IDLE;
						end
					end
					default:         nxt.phase = PH_IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/button_click_classifier.sv =====
// Top level of the button click classifier.
//
// Channels: item (sink) carries either a button edge (action = 1, with the
// level after the edge) or a tick (action = 0, with elapsed milliseconds).
// result (source) returns one beat per item: the click event (none, single,
// double or long) and busy_res, high while the phase is not idle so that a
// sleep request can be refused. cfg (sink) writes click_ms, hold_ms and
// ignore_ms by index; it is always ready and an index beyond the list is
// dropped. Write configuration only while the block is idle.
//
// Output: the result beat is offered in the cycle after the item beat.
// Throughput: one item per cycle unless stalled; the update is a single
// add, compare and phase select feeding the state and result registers.
// Stall: while a result is held and result.ready is low, item.ready drops;
// the next item is taken in the same cycle the held result leaves.
// Reset: phase idle, timer and pending edge cleared, latched level released,
// registers back to 300 / 1000 / 500 ms, no result offered.
`default_nettype none
module button_click_classifier
	import bcc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	bcc_item_if.sink           item,
	bcc_result_if.source       result,
	bcc_cfg_if.sink            cfg
);

	bcc_state_t  state_q;
	bcc_state_t  state_nxt;
	bcc_cfg_t    cfg_q;
	bcc_event_t  ev_nxt;
	logic        res_valid_q;
	bcc_event_t  res_event_q;
	logic        res_busy_q;
	logic        item_acc;

	// take a new item whenever the result register is empty or draining
	assign item.ready = !res_valid_q || result.ready;
	assign item_acc   = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_ms  <= ClickMsReset;
			cfg_q.hold_ms   <= HoldMsReset;
			cfg_q.ignore_ms <= IgnoreMsReset;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				RegClickMs:  cfg_q.click_ms  <= cfg.data;
				RegHoldMs:   cfg_q.hold_ms   <= cfg.data;
				RegIgnoreMs: cfg_q.ignore_ms <= cfg.data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	bcc_core u_core (
		.cur          (state_q),
		.cfg          (cfg_q),
		.action       (item.action),
		.elapsed_ms   (item.elapsed_ms),
		.button_level (item.button_level),
		.nxt          (state_nxt),
		.click_event  (ev_nxt)
	);

	// classifier state: advance on every accepted item beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= PH_IDLE;
			state_q.timer   <= '0;
			state_q.pending <= 1'b0;
			state_q.level   <= 1'b0;
		end else if (item_acc) begin
			state_q <= state_nxt;
		end
	end

	// result register: valid under reset, payload loaded with each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item_acc) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			res_event_q <= ev_nxt;
			res_busy_q  <= (state_nxt.phase != PH_IDLE);
		end
	end

	assign result.valid       = res_valid_q;
	assign result.click_event = res_event_q;
	assign result.busy_res    = res_busy_q;

endmodule
`default_nettype wire

// ===== rtl/bcc_checker.sv =====
// Port-level checks on the button click classifier, bound to the top level.
`default_nettype none
module bcc_checker
	import bcc_pkg::*;
(
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           item_valid,
	input wire logic           item_ready,
	input wire logic           item_action,
	input wire logic           res_valid,
	input wire logic           res_ready,
	input wire logic [EvW-1:0] res_event,
	input wire logic           res_busy,
	input wire logic           cfg_valid,
	input wire logic           cfg_ready
);

	// a held result keeps its beat
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_event) && $stable(res_busy))
		else $error("held result beat changed");

	// no new item while the result register is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !item_ready)
		else $error("item accepted over a stalled result");

	// an edge beat yields a result with no event on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_action |=> res_valid && res_event == EV_NONE)
		else $error("edge beat did not give an empty result");

	// configuration writes are never back-pressured
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration channel stalled");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_action (item.action),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_event   (result.click_event),
	.res_busy    (result.busy_res),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);
`default_nettype wire

// ===== test/button_click_classifier_test.sv =====
// Self-checking testbench for the button click classifier: directed table, then random gestures.
`timescale 1ns / 1ps

module button_click_classifier_test;
	import bcc_pkg::*;

	// item codes: a beat is either a tick of elapsed time or a button edge
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_EDGE = 1'b1;
	localparam logic LVL_UP   = 1'b0;
	localparam logic LVL_DOWN = 1'b1;

	localparam int STALL_LIMIT = 2000; // cycles with no beat on any channel
	localparam int HOLD_CYCLES = 64;   // long receiver hold-off
	localparam int DRAIN_WAIT  = 4;    // margin for the result registered after its item
	localparam int NUM_DIRECTED = 24;
	localparam int RANDOM_PER_PHASE = 170;

	typedef struct packed {
		bcc_event_t click_event;
		logic       busy;
	} click_res_t;

	typedef struct {
		logic       act;
		logic [7:0] dt;
		logic       lvl;
		bit         typed;  // expected result written into the row
		click_res_t want;
	} stim_row_t;

	localparam click_res_t QUIET_IDLE = '{EV_NONE, 1'b0};
	localparam click_res_t QUIET_BUSY = '{EV_NONE, 1'b1};
	localparam click_res_t DOUBLE_HIT = '{EV_DOUBLE, 1'b1};

	logic clk;
	logic arst_n;

	bcc_item_if   item_ch ();
	bcc_result_if res_ch ();
	bcc_cfg_if    cfg_ch ();

	button_click_classifier u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// Predictor state: mirrors the classifier's phase, timer and pending edge.
	bcc_phase_t     pred_phase;
	logic [MsW-1:0] pred_timer;
	logic           pred_pending;
	logic           pred_level;
	logic [MsW-1:0] lim_click;
	logic [MsW-1:0] lim_hold;
	logic [MsW-1:0] lim_ignore;

	click_res_t awaited_clicks [$];
	int         mismatch_count;
	int         send_idle_pct;
	int         recv_idle_pct;
	bit         hold_req;
	int         hold_left;
	int         quiet_cycles;
	logic       gesture_level;

	// Directed rows walked in order after reset, at the reset timings (300 / 1000 / 500).
	stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
		// ticks while idle: timer must not move, nothing busy
		'{ACT_TICK, 8'd0,   LVL_UP,   1'b1, QUIET_IDLE},
		'{ACT_TICK, 8'd255, LVL_DOWN, 1'b1, QUIET_IDLE},
		// several edges before a tick: only the last level counts
		'{ACT_EDGE, 8'd0,   LVL_DOWN, 1'b1, QUIET_IDLE},
		'{ACT_EDGE, 8'd255, LVL_UP,   1'b1, QUIET_IDLE},
		'{ACT_EDGE, 8'd0,   LVL_DOWN, 1'b1, QUIET_IDLE},
		'{ACT_TICK, 8'd10,  LVL_UP,   1'b1, QUIET_BUSY},
		// release, press, release inside click_ms: double click into ignore
		'{ACT_EDGE, 8'd0,   LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd20,  LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_EDGE, 8'd0,   LVL_DOWN, 1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd5,   LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_EDGE, 8'd0,   LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd5,   LVL_UP,   1'b1, DOUBLE_HIT},
		// press during ignore is swallowed, then ignore runs out
		'{ACT_EDGE, 8'd0,   LVL_DOWN, 1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd100, LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd255, LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd255, LVL_UP,   1'b0, QUIET_IDLE},
		// press and hold past hold_ms: first hold, then long click
		'{ACT_EDGE, 8'd0,   LVL_DOWN, 1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd1,   LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd255, LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd255, LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd255, LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd255, LVL_UP,   1'b0, QUIET_IDLE},
		// release while idle: an edge that leads nowhere
		'{ACT_EDGE, 8'd0,   LVL_UP,   1'b0, QUIET_IDLE},
		'{ACT_TICK, 8'd0,   LVL_UP,   1'b0, QUIET_IDLE}
	};

	// Advance the predicted classifier by one item and return its result.
	function automatic click_res_t classify_step(logic act, logic [7:0] dt, logic lvl);
		click_res_t res;
		logic       take;
		logic [MsW:0] sum;
		bcc_event_t ev;
		ev = EV_NONE;
		if (act == ACT_EDGE) begin
			pred_level   = lvl;
			pred_pending = 1'b1;
		end else begin
			take = pred_pending && (pred_phase != PH_IDLE ? pred_phase != PH_IGNORE : 1'b1);
			pred_pending = 1'b0;
			// timeouts first; the timer stands still while idle
			if (pred_phase != PH_IDLE) begin
				sum = {1'b0, pred_timer} + dt;
				pred_timer = sum[MsW] ? '1 : sum[MsW-1:0];
				case (pred_phase)
					PH_FIRSTPRESS:
						if (pred_timer > lim_click) pred_phase = PH_FIRSTHOLD;
					PH_FIRSTHOLD:
						if (pred_timer > lim_hold) begin
							ev = EV_LONG;
							pred_phase = PH_IDLE;
						end
					PH_FIRSTRELEASE:
						if (pred_timer > lim_click) begin
							ev = EV_SINGLE;
							pred_phase = PH_IDLE;
						end
					PH_SECONDPRESS:
						if (pred_timer > lim_click) pred_phase = PH_IDLE;
					PH_IGNORE:
						if (pred_timer > lim_ignore) pred_phase = PH_IDLE;
					default: ;
				endcase
			end
			// then the pending edge moves the phase reached above
			if (take) begin
				pred_timer = '0;
				case (pred_phase)
					PH_IDLE:         pred_phase = pred_level ? PH_FIRSTPRESS : PH_IDLE;
					PH_FIRSTPRESS:   pred_phase = pred_level ? PH_IDLE : PH_FIRSTRELEASE;
					PH_FIRSTRELEASE: pred_phase = pred_level ? PH_SECONDPRESS : PH_IDLE;
					PH_SECONDPRESS:
						if (!pred_level) begin
							ev = EV_DOUBLE;
							pred_phase = PH_IGNORE;
						end else begin
							pred_phase = PH_IDLE;
						end
					default:         pred_phase = PH_IDLE;
				endcase
			end
		end
		res.click_event = ev;
		res.busy        = (pred_phase != PH_IDLE);
		return res;
	endfunction

	function automatic stim_row_t mk_row(logic act, logic [7:0] dt, logic lvl);
		stim_row_t row;
		row.act   = act;
		row.dt    = dt;
		row.lvl   = lvl;
		row.typed = 1'b0;
		row.want  = QUIET_IDLE;
		return row;
	endfunction

	// Tick length scaled to click_ms so that timeouts are reached but not always.
	function automatic logic [7:0] pick_dt();
		int span;
		logic [7:0] d;
		span = lim_click >> 2;
		if (span < 1) span = 1;
		if (span > 255) span = 255;
		case ($urandom_range(0, 7))
			0:       d = 8'd0;
			1:       d = 8'd255;
			2, 3:    d = 8'($urandom_range(0, 255));
			default: d = 8'($urandom_range(0, span));
		endcase
		return d;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Offer one item beat, with random idle cycles ahead of it; record the
	// expectation on the edge that accepts it.
	task automatic send_item(stim_row_t row);
		click_res_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.action       <= row.act;
		item_ch.elapsed_ms   <= row.dt;
		item_ch.button_level <= row.lvl;
		do @(posedge clk); while (!item_ch.ready);
		res = classify_step(row.act, row.dt, row.lvl);
		awaited_clicks.push_back(row.typed ? row.want : res);
	endtask

	// Write all three timing registers back to back, valid held high throughout.
	task automatic load_timings(logic [MsW-1:0] click, logic [MsW-1:0] hold,
			logic [MsW-1:0] ign);
		logic [IdxW-1:0] idx [3];
		logic [MsW-1:0]  val [3];
		idx = '{RegClickMs, RegHoldMs, RegIgnoreMs};
		val = '{click, hold, ign};
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
			case (idx[i])
				RegClickMs:  lim_click  = val[i];
				RegHoldMs:   lim_hold   = val[i];
				RegIgnoreMs: lim_ignore = val[i];
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly well-formed press/release gestures with random timing, plus noise.
	task automatic random_gestures(int count);
		stim_row_t row;
		int sent;
		int r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			row = mk_row(ACT_TICK, 8'($urandom), 1'($urandom));
			if (r < 40) begin
				// edge with the opposite level, applied by the tick that follows
				gesture_level = ~gesture_level;
				row.act = ACT_EDGE;
				row.lvl = gesture_level;
				send_item(row);
				send_item(mk_row(ACT_TICK, pick_dt(), 1'($urandom)));
				sent += 2;
			end else if (r < 48) begin
				row.act = ACT_EDGE;
				send_item(row);
				sent++;
			end else begin
				row.dt = pick_dt();
				send_item(row);
				sent++;
			end
		end
	endtask

	// With every limit at its maximum, drive the timer into saturation while
	// first press and again while ignore.
	task automatic saturate_timers();
		send_item(mk_row(ACT_EDGE, 8'd0, LVL_DOWN));
		send_item(mk_row(ACT_TICK, 8'd0, LVL_UP));
		repeat (270) send_item(mk_row(ACT_TICK, 8'd255, LVL_UP));
		send_item(mk_row(ACT_EDGE, 8'd0, LVL_UP));
		send_item(mk_row(ACT_TICK, 8'd255, LVL_UP));
		send_item(mk_row(ACT_EDGE, 8'd0, LVL_DOWN));
		send_item(mk_row(ACT_TICK, 8'd255, LVL_UP));
		send_item(mk_row(ACT_EDGE, 8'd0, LVL_UP));
		send_item(mk_row(ACT_TICK, 8'd255, LVL_UP));
		repeat (260) send_item(mk_row(ACT_TICK, 8'd255, LVL_UP));
		gesture_level = LVL_UP;
	endtask

	task automatic drain_results();
		while (awaited_clicks.size() != 0) @(posedge clk);
	endtask

	// Result side: check each accepted beat, then decide the next ready.
	always @(posedge clk) begin
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (awaited_clicks.size() == 0) begin
				flag_mismatch($sformatf("result event %0d busy %0b with nothing expected",
					res_ch.click_event, res_ch.busy_res));
			end else begin
				if (res_ch.click_event !== awaited_clicks[0].click_event)
					flag_mismatch($sformatf("click_event %0d, expected %0d",
						res_ch.click_event, awaited_clicks[0].click_event));
				if (res_ch.busy_res !== awaited_clicks[0].busy)
					flag_mismatch($sformatf("busy_res %0b, expected %0b",
						res_ch.busy_res, awaited_clicks[0].busy));
				void'(awaited_clicks.pop_front());
			end
		end
		// a long hold-off, counted here, lets the block fill and stall its input
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("button_click_classifier_test: FAIL");
			$finish;
		end
	end

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.action       = ACT_TICK;
		item_ch.elapsed_ms   = '0;
		item_ch.button_level = LVL_UP;
		res_ch.ready         = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = RegClickMs;
		cfg_ch.data          = '0;
		pred_phase           = PH_IDLE;
		pred_timer           = '0;
		pred_pending         = 1'b0;
		pred_level           = LVL_UP;
		lim_click            = ClickMsReset;
		lim_hold             = HoldMsReset;
		lim_ignore           = IgnoreMsReset;
		mismatch_count       = 0;
		hold_req             = 1'b0;
		hold_left            = 0;
		quiet_cycles         = 0;
		gesture_level        = LVL_UP;
		send_idle_pct        = 19;
		recv_idle_pct        = 59;

		// hold reset, then release it on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset timings
		for (int i = 0; i < NUM_DIRECTED; i++) send_item(directed_rows[i]);
		item_ch.valid <= 1'b0;

		// random part: six settings, two per idling pattern
		for (int p = 0; p < 6; p++) begin
			drain_results();
			case (p)
				0: load_timings('0, '0, '0);
				1: load_timings('1, '1, '1);
				2: load_timings(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
					16'($urandom_range(0, 2000)));
				3: load_timings(16'd20, 16'd60, 16'd40);
				4: load_timings(ClickMsReset, HoldMsReset, IgnoreMsReset);
				default: load_timings(16'($urandom_range(0, 600)),
					16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)));
			endcase
			case (p / 2)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 59;
				end
				1: begin
					send_idle_pct = 59;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (p == 1) saturate_timers();
			if (p == 4) hold_req = 1'b1;
			random_gestures(RANDOM_PER_PHASE);
			item_ch.valid <= 1'b0;
		end

		// drain, allow for the result latency, then give the verdict
		drain_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && awaited_clicks.size() == 0) begin
			$display("button_click_classifier_test: PASS");
		end else begin
			$display("button_click_classifier_test: FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bcc_pkg.sv
rtl/bcc_if.sv
rtl/bcc_core.sv
rtl/button_click_classifier.sv
rtl/bcc_checker.sv
test/button_click_classifier_test.sv
